// ===== design/imts_pkg.sv =====
// Shared types and constants for the IMU timestamp interpolator.
// Used by every module of the block; depends on nothing.
`default_nettype none
package imts_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int NUM_VALS    = 10;
   localparam int QUAT_BASE   = 6;
   localparam logic [23:0] GAP_RESET = 24'd200000;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_SYNC = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FEW   = 2'd1,
      ST_EARLY = 2'd2,
      ST_GAP   = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      BK_IDLE, BK_LOOK, BK_RD0, BK_RD1, BK_CHECK, BK_DIV, BK_MUL, BK_ACC,
      BK_SQ, BK_SUM, BK_SQRT, BK_NPREP, BK_NORM, BK_NFIN, BK_DONE
   } back_state_type;

   typedef struct packed {
      logic               opcode;
      logic [39:0]        stamp_us;
      logic signed [31:0] accel_x;
      logic signed [31:0] accel_y;
      logic signed [31:0] accel_z;
      logic signed [31:0] rate_x;
      logic signed [31:0] rate_y;
      logic signed [31:0] rate_z;
      logic signed [31:0] quat_x;
      logic signed [31:0] quat_y;
      logic signed [31:0] quat_z;
      logic signed [31:0] quat_w;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [39:0]        out_stamp_us;
      logic signed [31:0] out_accel_x;
      logic signed [31:0] out_accel_y;
      logic signed [31:0] out_accel_z;
      logic signed [31:0] out_rate_x;
      logic signed [31:0] out_rate_y;
      logic signed [31:0] out_rate_z;
      logic signed [31:0] out_quat_x;
      logic signed [31:0] out_quat_y;
      logic signed [31:0] out_quat_z;
      logic signed [31:0] out_quat_w;
   } rsp_type;

   // one stored sample: time plus the ten values, accel first, quat last
   typedef struct packed {
      logic [39:0]                 stamp;
      logic [NUM_VALS-1:0][31:0]   vals;
   } row_type;

   typedef struct packed {
      op_type  op;
      row_type row;
   } cmd_type;

endpackage
`default_nettype wire

// ===== design/imts_front.sv =====
// Front end: accepts request transactions, decodes the opcode and packs the
// sample into a row, then holds it in a two-entry queue. Uses imts_pkg.
`default_nettype none
module imts_front
   import imts_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         cmd_valid,
   input  wire logic    cmd_ready,
   output cmd_type      cmd
);

   cmd_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   cmd_type    dec;
   logic       push, pop;

   always_comb begin
      dec.op            = req_data.opcode ? OP_SYNC : OP_PUSH;
      dec.row.stamp     = req_data.stamp_us;
      dec.row.vals[0]   = req_data.accel_x;
      dec.row.vals[1]   = req_data.accel_y;
      dec.row.vals[2]   = req_data.accel_z;
      dec.row.vals[3]   = req_data.rate_x;
      dec.row.vals[4]   = req_data.rate_y;
      dec.row.vals[5]   = req_data.rate_z;
      dec.row.vals[6]   = req_data.quat_x;
      dec.row.vals[7]   = req_data.quat_y;
      dec.row.vals[8]   = req_data.quat_z;
      dec.row.vals[9]   = req_data.quat_w;
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule
`default_nettype wire

// ===== design/imts_back.sv =====
// Back end: sample store, sync sequencer, divider, blend, square root and
// quaternion normalisation, plus the response register. Uses imts_pkg.
`default_nettype none
module imts_back
   import imts_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [23:0] csr_wr_data,
   input  wire logic        cmd_valid,
   output logic             cmd_ready,
   input  wire cmd_type     cmd,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data
);

   back_state_type state_ff, state_in;

   row_type                  mem [QUEUE_DEPTH];
   row_type                  rd_data_ff;
   logic [PTR_W-1:0]         rd_addr, wr_slot;
   logic                     mem_we;

   logic [PTR_W-1:0]         oldest_ff, oldest_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [23:0]              gap_ff;
   logic [39:0]              stamp_ff, stamp_in;
   status_type               status_ff, status_in;
   row_type                  row0_ff, row0_in, row1_ff, row1_in;
   logic [39:0]              rem_ff, rem_in, den_ff, den_in;
   logic [30:0]              wb_ff, wb_in;
   logic [4:0]               step_ff, step_in;
   logic [3:0]               idx_ff, idx_in;
   logic signed [63:0]       prod_ff, prod_in;
   logic [NUM_VALS-1:0][31:0] vals_ff, vals_in;
   logic [63:0]              sum_ff, sum_in;
   logic [63:0]              n_ff, n_in, res_ff, res_in, bit_ff, bit_in;
   logic [3:0][31:0]         nrem_ff, nrem_in, nquo_ff, nquo_in, nlow_ff, nlow_in;
   logic [3:0]               nsat_ff, nsat_in;
   rsp_type                  rsp_ff, rsp_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic [39:0] t0, t1, diff_t, lead_t, den_t;
   logic        c_early, c_pass, c_gap0, c_gap1, rsp_free, is_sync, is_push;
   logic [PTR_W:0] slot_sum;

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] s);
      return (s == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : s + 1'b1;
   endfunction

   assign t0       = row0_ff.stamp;
   assign t1       = row1_ff.stamp;
   assign diff_t   = stamp_ff - t0;
   assign lead_t   = t1 - stamp_ff;
   assign den_t    = t1 - t0;
   assign c_early  = t0 > stamp_ff;
   assign c_pass   = t1 < stamp_ff;
   assign c_gap0   = diff_t > {16'd0, gap_ff};
   assign c_gap1   = lead_t > {16'd0, gap_ff};
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign is_sync  = cmd_valid && (state_ff == BK_IDLE) && (cmd.op == OP_SYNC);
   assign is_push  = cmd_valid && (state_ff == BK_IDLE) && (cmd.op == OP_PUSH);

   assign cmd_ready = (state_ff == BK_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // store slot for a push: overwrite the oldest when full
   assign slot_sum = (PTR_W+1)'(oldest_ff) + (PTR_W+1)'(count_ff);
   always_comb begin
      if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
         wr_slot = oldest_ff;
      end else if (slot_sum >= (PTR_W+1)'(QUEUE_DEPTH)) begin
         wr_slot = PTR_W'(slot_sum - (PTR_W+1)'(QUEUE_DEPTH));
      end else begin
         wr_slot = PTR_W'(slot_sum);
      end
   end

   assign mem_we  = is_push;
   assign rd_addr = (state_ff == BK_RD0) ? next_slot(oldest_ff) : oldest_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_slot] <= cmd.row;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (is_sync) begin
               state_in = (count_ff < CNT_W'(2)) ? BK_DONE : BK_LOOK;
            end
         end
         BK_LOOK:  state_in = BK_RD0;
         BK_RD0:   state_in = BK_RD1;
         BK_RD1:   state_in = BK_CHECK;
         BK_CHECK: begin
            if (c_early) begin
               state_in = BK_DONE;
            end else if (c_pass) begin
               state_in = (count_ff == CNT_W'(2)) ? BK_DONE : BK_LOOK;
            end else if (c_gap0 || c_gap1) begin
               state_in = BK_DONE;
            end else begin
               state_in = (den_t == 40'd0) ? BK_MUL : BK_DIV;
            end
         end
         BK_DIV:   state_in = (step_ff == 5'd0) ? BK_MUL : BK_DIV;
         BK_MUL:   state_in = BK_ACC;
         BK_ACC:   state_in = (idx_ff == 4'(NUM_VALS - 1)) ? BK_SQ : BK_MUL;
         BK_SQ:    state_in = BK_SUM;
         BK_SUM:   state_in = (idx_ff == 4'(NUM_VALS - 1)) ? BK_SQRT : BK_SQ;
         BK_SQRT:  state_in = (step_ff == 5'd0) ? BK_NPREP : BK_SQRT;
         BK_NPREP: state_in = (res_ff[31:0] == 32'd0) ? BK_DONE : BK_NORM;
         BK_NORM:  state_in = (step_ff == 5'd0) ? BK_NFIN : BK_NORM;
         BK_NFIN:  state_in = BK_DONE;
         BK_DONE:  state_in = rsp_free ? BK_IDLE : BK_DONE;
         default:  state_in = BK_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      logic signed [31:0] v0, v1, qv;
      logic signed [32:0] dv;
      logic signed [64:0] mul_full;
      logic signed [63:0] acc;
      logic [40:0]        rem2;
      logic [63:0]        tmp, num;
      logic [31:0]        mag, rr;
      logic [32:0]        nrem2;
      logic               ge;

      oldest_in    = oldest_ff;
      count_in     = count_ff;
      stamp_in     = stamp_ff;
      status_in    = status_ff;
      row0_in      = row0_ff;
      row1_in      = row1_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      wb_in        = wb_ff;
      step_in      = step_ff;
      idx_in       = idx_ff;
      prod_in      = prod_ff;
      vals_in      = vals_ff;
      sum_in       = sum_ff;
      n_in         = n_ff;
      res_in       = res_ff;
      bit_in       = bit_ff;
      nrem_in      = nrem_ff;
      nquo_in      = nquo_ff;
      nlow_in      = nlow_ff;
      nsat_in      = nsat_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      v0       = $signed(row0_ff.vals[idx_ff]);
      v1       = $signed(row1_ff.vals[idx_ff]);
      qv       = $signed(vals_ff[idx_ff]);
      dv       = {v1[31], v1} - {v0[31], v0};
      mul_full = '0;
      acc      = '0;
      rem2     = '0;
      tmp      = '0;
      num      = '0;
      mag      = '0;
      rr       = res_ff[31:0];
      nrem2    = '0;
      ge       = 1'b0;

      case (state_ff)
         BK_IDLE: begin
            if (is_push) begin
               if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
                  oldest_in = next_slot(oldest_ff);
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end else if (is_sync) begin
               stamp_in  = cmd.row.stamp;
               status_in = (count_ff < CNT_W'(2)) ? ST_FEW : ST_OK;
            end
         end
         BK_RD0: row0_in = rd_data_ff;
         BK_RD1: row1_in = rd_data_ff;
         BK_CHECK: begin
            if (c_early) begin
               status_in = ST_EARLY;
            end else if (c_pass) begin
               oldest_in = next_slot(oldest_ff);
               count_in  = count_ff - 1'b1;
               if (count_ff == CNT_W'(2)) begin
                  status_in = ST_FEW;
               end
            end else if (c_gap0) begin
               oldest_in = next_slot(oldest_ff);
               count_in  = count_ff - 1'b1;
               status_in = ST_GAP;
            end else if (c_gap1) begin
               status_in = ST_GAP;
            end else begin
               idx_in  = '0;
               sum_in  = '0;
               den_in  = den_t;
               step_in = 5'd29;
               // weight quotient can reach one only when target equals t1
               ge      = (den_t != 40'd0) && (diff_t >= den_t);
               rem_in  = ge ? diff_t - den_t : diff_t;
               wb_in   = {30'd0, ge};
            end
         end
         BK_DIV: begin
            rem2    = {rem_ff, 1'b0};
            ge      = rem2 >= {1'b0, den_ff};
            rem_in  = ge ? 40'(rem2 - {1'b0, den_ff}) : rem2[39:0];
            wb_in   = {wb_ff[29:0], ge};
            step_in = step_ff - 1'b1;
         end
         BK_MUL: begin
            mul_full = dv * $signed({1'b0, wb_ff});
            prod_in  = mul_full[63:0];
         end
         BK_ACC: begin
            // v0*2^30 + (v1-v0)*wb, rounded half up
            acc = $signed({{2{v0[31]}}, v0, 30'd0}) + prod_ff + 64'sd536870912;
            vals_in[idx_ff] = acc[61:30];
            idx_in = (idx_ff == 4'(NUM_VALS - 1)) ? 4'(QUAT_BASE) : idx_ff + 1'b1;
         end
         BK_SQ: begin
            mul_full = qv * qv;
            prod_in  = mul_full[63:0];
         end
         BK_SUM: begin
            tmp    = sum_ff + {2'd0, prod_ff[63:2]};
            sum_in = tmp;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == 4'(NUM_VALS - 1)) begin
               n_in    = tmp;
               res_in  = '0;
               bit_in  = 64'h4000_0000_0000_0000;
               step_in = 5'd31;
            end
         end
         BK_SQRT: begin
            tmp = res_ff + bit_ff;
            if (n_ff >= tmp) begin
               n_in   = n_ff - tmp;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in  = bit_ff >> 2;
            step_in = step_ff - 1'b1;
         end
         BK_NPREP: begin
            if (rr == 32'd0) begin
               vals_in[QUAT_BASE]     = 32'd0;
               vals_in[QUAT_BASE + 1] = 32'd0;
               vals_in[QUAT_BASE + 2] = 32'd0;
               vals_in[QUAT_BASE + 3] = 32'h4000_0000;
            end else begin
               step_in = 5'd31;
               for (int l = 0; l < 4; l++) begin
                  mag = vals_ff[QUAT_BASE + l][31] ? ~vals_ff[QUAT_BASE + l] + 1'b1
                                                  : vals_ff[QUAT_BASE + l];
                  num = ({32'd0, mag} << 29) + {33'd0, rr[31:1]};
                  nsat_in[l] = num[63:32] >= rr;
                  nrem_in[l] = num[63:32];
                  nlow_in[l] = num[31:0];
                  nquo_in[l] = '0;
               end
            end
         end
         BK_NORM: begin
            step_in = step_ff - 1'b1;
            for (int l = 0; l < 4; l++) begin
               nrem2      = {nrem_ff[l], nlow_ff[l][31]};
               ge         = nrem2 >= {1'b0, rr};
               nrem_in[l] = ge ? 32'(nrem2 - {1'b0, rr}) : nrem2[31:0];
               nquo_in[l] = {nquo_ff[l][30:0], ge};
               nlow_in[l] = {nlow_ff[l][30:0], 1'b0};
            end
         end
         BK_NFIN: begin
            for (int l = 0; l < 4; l++) begin
               if (vals_ff[QUAT_BASE + l][31]) begin
                  if (nsat_ff[l] || nquo_ff[l] > 32'h8000_0000) begin
                     vals_in[QUAT_BASE + l] = 32'h8000_0000;
                  end else begin
                     vals_in[QUAT_BASE + l] = ~nquo_ff[l] + 1'b1;
                  end
               end else if (nsat_ff[l] || nquo_ff[l] > 32'h7FFF_FFFF) begin
                  vals_in[QUAT_BASE + l] = 32'h7FFF_FFFF;
               end else begin
                  vals_in[QUAT_BASE + l] = nquo_ff[l];
               end
            end
         end
         BK_DONE: begin
            if (rsp_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in              = '0;
               rsp_in.status       = status_ff;
               rsp_in.out_stamp_us = stamp_ff;
               if (status_ff == ST_OK) begin
                  rsp_in.out_accel_x = vals_ff[0];
                  rsp_in.out_accel_y = vals_ff[1];
                  rsp_in.out_accel_z = vals_ff[2];
                  rsp_in.out_rate_x  = vals_ff[3];
                  rsp_in.out_rate_y  = vals_ff[4];
                  rsp_in.out_rate_z  = vals_ff[5];
                  rsp_in.out_quat_x  = vals_ff[6];
                  rsp_in.out_quat_y  = vals_ff[7];
                  rsp_in.out_quat_z  = vals_ff[8];
                  rsp_in.out_quat_w  = vals_ff[9];
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         oldest_ff    <= '0;
         count_ff     <= '0;
         gap_ff       <= GAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         oldest_ff    <= oldest_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            gap_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      stamp_ff  <= stamp_in;
      status_ff <= status_in;
      row0_ff   <= row0_in;
      row1_ff   <= row1_in;
      rem_ff    <= rem_in;
      den_ff    <= den_in;
      wb_ff     <= wb_in;
      step_ff   <= step_in;
      idx_ff    <= idx_in;
      prod_ff   <= prod_in;
      vals_ff   <= vals_in;
      sum_ff    <= sum_in;
      n_ff      <= n_in;
      res_ff    <= res_in;
      bit_ff    <= bit_in;
      nrem_ff   <= nrem_in;
      nquo_ff   <= nquo_in;
      nlow_ff   <= nlow_in;
      nsat_ff   <= nsat_in;
      rsp_ff    <= rsp_in;
   end

endmodule
`default_nettype wire

// ===== design/imu_timestamp_sync_interpolator.sv =====
// Push: handled in the back end's idle state after the two-entry front queue;
// pushes flow at one per cycle while the back end is idle. Sync: when it
// interpolates, runs a 30-step divider, ten blends, a 32-step square root and
// a 32-step normaliser; each dropped sample repeats LOOK, RD0, RD1 and CHECK.
// One sync at a time. Synchronous reset empties the queue, gap = 200000 us.
`default_nettype none
module imu_timestamp_sync_interpolator
   import imts_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_wr_en,
   input  wire logic [23:0] csr_wr_data
);

   cmd_type cmd;
   logic    cmd_valid, cmd_ready;

   imts_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   imts_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd_valid   (cmd_valid),
      .cmd_ready   (cmd_ready),
      .cmd         (cmd),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule
`default_nettype wire

// ===== design/imts_checker.sv =====
// Port-level checks for the interpolator, bound to the top level.
// Uses imts_pkg.
`default_nettype none
module imts_checker
   import imts_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |->
         rsp_data.out_accel_x == 0 && rsp_data.out_accel_y == 0 &&
         rsp_data.out_accel_z == 0 && rsp_data.out_rate_x == 0 &&
         rsp_data.out_rate_y == 0 && rsp_data.out_rate_z == 0 &&
         rsp_data.out_quat_x == 0 && rsp_data.out_quat_y == 0 &&
         rsp_data.out_quat_z == 0 && rsp_data.out_quat_w == 0)
      else $error("error response carries non-zero values");

endmodule

bind imu_timestamp_sync_interpolator imts_checker u_chk (.*);
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for imu_timestamp_sync_interpolator: directed and random
// push/sync traffic, checked against an in-bench interpolation predictor.
// Depends on imts_pkg and the block's RTL only.
`default_nettype none
module tb_top;
   import imts_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE_CYCLES = 200;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wr_en = 1'b0;
   logic [23:0] csr_wr_data = '0;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int fail_count = 0;
   int cycle_count = 0;

   // sample store mirror
   logic [39:0] hist_stamp[QUEUE_DEPTH];
   logic [31:0] hist_val[QUEUE_DEPTH][NUM_VALS];
   int          hist_head = 0;
   int          hist_count = 0;
   logic [23:0] gap_limit = GAP_RESET;

   rsp_type sync_answers[$];

   always #6 clock = ~clock;

   imu_timestamp_sync_interpolator i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   function automatic void store_sample(req_type it);
      int slot;
      if (hist_count >= QUEUE_DEPTH) begin
         slot = hist_head;
         hist_head = (hist_head + 1) % QUEUE_DEPTH;
      end else begin
         slot = (hist_head + hist_count) % QUEUE_DEPTH;
         hist_count++;
      end
      hist_stamp[slot]  = it.stamp_us;
      hist_val[slot][0] = it.accel_x;
      hist_val[slot][1] = it.accel_y;
      hist_val[slot][2] = it.accel_z;
      hist_val[slot][3] = it.rate_x;
      hist_val[slot][4] = it.rate_y;
      hist_val[slot][5] = it.rate_z;
      hist_val[slot][6] = it.quat_x;
      hist_val[slot][7] = it.quat_y;
      hist_val[slot][8] = it.quat_z;
      hist_val[slot][9] = it.quat_w;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic rsp_type interpolate_sync(logic [39:0] target);
      rsp_type         res;
      status_type      st;
      logic [39:0]     t0, t1;
      int              h0, h1;
      longint          wb, wf, acc;
      longint          blended[NUM_VALS];
      longint unsigned sq_sum, root, mag, quo;
      res = '0;
      res.out_stamp_us = target;
      st = ST_FEW;
      while (hist_count >= 2) begin
         t0 = hist_stamp[hist_head];
         t1 = hist_stamp[(hist_head + 1) % QUEUE_DEPTH];
         if (t0 > target) begin
            st = ST_EARLY;
            break;
         end
         if (t1 < target) begin
            hist_head = (hist_head + 1) % QUEUE_DEPTH;
            hist_count--;
            continue;
         end
         if (target - t0 > {16'd0, gap_limit}) begin
            hist_head = (hist_head + 1) % QUEUE_DEPTH;
            hist_count--;
            st = ST_GAP;
            break;
         end
         if (t1 - target > {16'd0, gap_limit}) begin
            st = ST_GAP;
            break;
         end
         st = ST_OK;
         break;
      end
      res.status = st;
      if (st != ST_OK) return res;

      h0 = hist_head;
      h1 = (hist_head + 1) % QUEUE_DEPTH;
      t0 = hist_stamp[h0];
      t1 = hist_stamp[h1];
      wb = 0;
      if (t1 != t0)
         wb = longint'(((64'(target - t0)) << 30) / 64'(t1 - t0));
      wf = (longint'(1) << 30) - wb;
      sq_sum = 0;
      for (int k = 0; k < NUM_VALS; k++) begin
         acc = longint'($signed(hist_val[h0][k])) * wf
             + longint'($signed(hist_val[h1][k])) * wb;
         blended[k] = (acc + (longint'(1) << 29)) >>> 30;
         if (k >= QUAT_BASE) sq_sum += longint'(blended[k] * blended[k]) >> 2;
      end
      res.out_accel_x = blended[0][31:0];
      res.out_accel_y = blended[1][31:0];
      res.out_accel_z = blended[2][31:0];
      res.out_rate_x  = blended[3][31:0];
      res.out_rate_y  = blended[4][31:0];
      res.out_rate_z  = blended[5][31:0];
      root = int_sqrt(sq_sum);
      // degenerate quaternion falls back to identity
      if (root == 0) begin
         res.out_quat_w = 32'sd1 << 30;
      end else begin
         for (int k = QUAT_BASE; k < NUM_VALS; k++) begin
            mag = (blended[k] < 0) ? -blended[k] : blended[k];
            quo = ((mag << 29) + (root >> 1)) / root;
            if (blended[k] < 0) begin
               if (quo > 64'h8000_0000) quo = 64'h8000_0000;
               blended[k] = -longint'(quo);
            end else begin
               if (quo > 64'h7FFF_FFFF) quo = 64'h7FFF_FFFF;
               blended[k] = longint'(quo);
            end
         end
         res.out_quat_x = blended[6][31:0];
         res.out_quat_y = blended[7][31:0];
         res.out_quat_z = blended[8][31:0];
         res.out_quat_w = blended[9][31:0];
      end
      return res;
   endfunction

   // call at a rising edge; returns at the edge where the transaction is taken
   task automatic send_item(req_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!(req_valid && req_ready));
      if (it.opcode == OP_PUSH) store_sample(it);
      else sync_answers.push_back(interpolate_sync(it.stamp_us));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sync_answers.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_gap(logic [23:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      gap_limit = value;
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic req_type make_push(logic [39:0] stamp, logic [31:0] fill,
                                         logic [31:0] quat);
      req_type it;
      it = '0;
      it.opcode   = OP_PUSH;
      it.stamp_us = stamp;
      {it.accel_x, it.accel_y, it.accel_z, it.rate_x, it.rate_y, it.rate_z}
         = {6{fill}};
      {it.quat_x, it.quat_y, it.quat_z, it.quat_w} = {4{quat}};
      return it;
   endfunction

   function automatic req_type make_sync(logic [39:0] stamp);
      req_type it;
      it = '0;
      it.opcode   = OP_SYNC;
      it.stamp_us = stamp;
      return it;
   endfunction

   function automatic req_type random_push(logic [39:0] stamp);
      req_type it;
      it = req_type'($bits(req_type)'({$urandom, $urandom, $urandom, $urandom,
                                       $urandom, $urandom, $urandom, $urandom,
                                       $urandom, $urandom, $urandom, $urandom}));
      it.opcode   = OP_PUSH;
      it.stamp_us = stamp;
      return it;
   endfunction

   task automatic test_too_few();
      send_item(make_sync(40'd0));
      send_item(make_push(40'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      send_item(make_sync(40'hFF_FFFF_FFFF));
   endtask

   task automatic test_extremes();
      send_item(make_push(40'd100, 32'h8000_0000, 32'h8000_0000));
      send_item(make_sync(40'd0));
      send_item(make_sync(40'd50));
      send_item(make_sync(40'd100));
   endtask

   task automatic test_early_target();
      send_item(make_push(40'd1000, 32'h0001_0000, 32'h4000_0000));
      send_item(make_sync(40'd500));   // drops the oldest, then interpolates
      send_item(make_sync(40'd50));    // now before the oldest
   endtask

   task automatic test_gap_limit();
      send_item(make_push(40'd2_000_000, 32'hFFFF_0000, 32'hC000_0000));
      send_item(make_sync(40'd1_500_000)); // behind gap too wide
      send_item(make_sync(40'd1_900_000)); // one sample left
      send_item(make_push(40'd2_500_000, 32'h1234_5678, 32'h2000_0000));
      send_item(make_sync(40'd2_000_001)); // ahead gap too wide
   endtask

   task automatic test_equal_stamps();
      send_item(make_push(40'd3_000_000, 32'h0000_0001, 32'h1000_0000));
      send_item(make_push(40'd3_000_000, 32'h7000_0000, 32'hF000_0000));
      send_item(make_sync(40'd3_000_000));
      send_item(make_sync(40'd3_000_000));
   endtask

   task automatic test_null_quaternion();
      send_item(make_push(40'd3_000_010, 32'h0000_0005, 32'h0000_0000));
      send_item(make_sync(40'd3_000_005)); // halfway from a negative quaternion to a zero one
      send_item(make_push(40'd3_000_020, 32'hFFFF_FFFD, 32'h0000_0003));
      send_item(make_sync(40'd3_000_019)); // tiny quaternion
   endtask

   task automatic run_random(int n_items, int idle, int stall, int step_max);
      logic [39:0] now;
      req_type     it;
      send_idle_pct = idle;
      rsp_stall_pct = stall;
      now = {8'($urandom_range(0, 254)), 32'($urandom)};
      for (int i = 0; i < n_items; i++) begin
         if ($urandom_range(99) < 12) begin
            // noise: anything at all
            it = random_push(40'({$urandom, $urandom}));
            it.opcode = op_type'($urandom_range(1));
         end else if ($urandom_range(99) < 60) begin
            now = now + 40'($urandom_range(0, step_max));
            it = random_push(now);
         end else begin
            it = make_sync(now - 40'($urandom_range(0, 3 * step_max)));
         end
         send_item(it);
      end
   endtask

   // result checking
   task automatic check_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
         $error("%s: expected %h, got %h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (sync_answers.size() == 0) begin
            $error("unexpected result transaction: %p", rsp_data);
            fail_count++;
         end else begin
            want = sync_answers[0];
            sync_answers.delete(0);
            check_field("status", want.status, rsp_data.status);
            check_field("out_stamp_us", want.out_stamp_us, rsp_data.out_stamp_us);
            check_field("out_accel_x", 32'(want.out_accel_x), 32'(rsp_data.out_accel_x));
            check_field("out_accel_y", 32'(want.out_accel_y), 32'(rsp_data.out_accel_y));
            check_field("out_accel_z", 32'(want.out_accel_z), 32'(rsp_data.out_accel_z));
            check_field("out_rate_x", 32'(want.out_rate_x), 32'(rsp_data.out_rate_x));
            check_field("out_rate_y", 32'(want.out_rate_y), 32'(rsp_data.out_rate_y));
            check_field("out_rate_z", 32'(want.out_rate_z), 32'(rsp_data.out_rate_z));
            check_field("out_quat_x", 32'(want.out_quat_x), 32'(rsp_data.out_quat_x));
            check_field("out_quat_y", 32'(want.out_quat_y), 32'(rsp_data.out_quat_y));
            check_field("out_quat_z", 32'(want.out_quat_z), 32'(rsp_data.out_quat_z));
            check_field("out_quat_w", 32'(want.out_quat_w), 32'(rsp_data.out_quat_w));
         end
      end
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_too_few();
      test_extremes();
      test_early_target();
      test_gap_limit();
      test_equal_stamps();
      test_null_quaternion();

      run_random(150, 0, 0, 60_000);
      set_gap(24'd0);
      run_random(100, 57, 0, 3);
      set_gap(24'hFF_FFFF);
      run_random(150, 0, 57, 4_000_000);
      set_gap(24'd5000);
      run_random(200, 6, 6, 2500);

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && sync_answers.size() == 0) begin
         $display("tb_top OK");
      end else begin
         if (sync_answers.size() != 0) $error("%0d results never arrived", sync_answers.size());
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ===== sim.f =====
design/imts_pkg.sv
design/imts_front.sv
design/imts_back.sv
design/imu_timestamp_sync_interpolator.sv
design/imts_checker.sv
tb/sv/tb_top.sv
